>>> rtl/mss_pkg.sv
package mss_pkg;

  // Fixed field and register widths
  localparam int REQ_W     = 1;
  localparam int STK_W     = 2;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 3;
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 7;
  localparam int FILL_W    = 7;

  // Stack sizes and the sum of the sizes that can sit below any stack
  localparam int SIZE_REGS  = 4;
  localparam int SIZE_LIMIT = 64;
  localparam int BASE_W     = 9;

  // Parameter defaults
  localparam int DEF_STACK_SLOTS = 4;
  localparam int DEF_MEM_DEPTH   = 256;

  // Reset values of the registers
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_THREE  = 3'd4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 1'b0;
  localparam logic [REQ_W-1:0] REQ_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_STACK = 2'd3
  } status_t;

  // Outcome of one request, from the controller to the datapath
  typedef struct packed {
    status_t status;
    logic    wr;
    logic    rd;
  } decision_t;

endpackage

>>> rtl/multi_stack_shared_memory.sv
// A taken request word passes the s1 stage, then the output word register.
// Throughput: one request per cycle unless the output stalls, bounded by the
// single port of the element memory (each request does one read or one write).
// Reset: fill counts clear, four stacks of 64 entries are configured; the
// element memory is not cleared and holds garbage until pushed.
module multi_stack_shared_memory import mss_pkg::*; #(
  parameter int STACK_SLOTS = DEF_STACK_SLOTS,
  parameter int MEM_DEPTH   = DEF_MEM_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [STK_W-1:0]     stack_number,
  input  logic [DATA_W-1:0]    push_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    pop_value,
  output logic [STATUS_W-1:0]  status
);

  localparam int AW = $clog2(MEM_DEPTH);

  decision_t         dec;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  logic              accept;
  logic              s1_valid;
  status_t           s1_status;
  logic              s1_read;
  logic              s1_adv;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  mss_ctrl #(
    .STACK_SLOTS (STACK_SLOTS),
    .MEM_DEPTH   (MEM_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .req_type     (req_type),
    .stack_number (stack_number),
    .dec          (dec),
    .addr         (mem_addr)
  );

  mss_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept && dec.wr),
    .re    (accept && dec.rd),
    .addr  (mem_addr),
    .wdata (push_value),
    .rdata (mem_rdata)
  );

  // Hold the outcome while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= dec.status;
      s1_read   <= dec.rd;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      status    <= s1_status;
      pop_value <= s1_read ? mem_rdata : '0;
    end
  end

  a_read_is_ok: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_read |-> s1_status == ST_OK)
    else $error("memory read issued for a failed request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> pop_value == '0)
    else $error("failed request returned a nonzero value");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room downstream");

endmodule

>>> rtl/mss_mem.sv
module mss_mem import mss_pkg::*; #(
  parameter int MEM_DEPTH = DEF_MEM_DEPTH,
  parameter int AW        = $clog2(MEM_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  // Single port: write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/mss_ctrl.sv
module mss_ctrl import mss_pkg::*; #(
  parameter int STACK_SLOTS = DEF_STACK_SLOTS,
  parameter int MEM_DEPTH   = DEF_MEM_DEPTH,
  parameter int AW          = $clog2(MEM_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [STK_W-1:0]     stack_number,
  output decision_t            dec,
  output logic [AW-1:0]        addr
);

  localparam int USED_SLOTS = (STACK_SLOTS < SIZE_REGS) ? STACK_SLOTS : SIZE_REGS;
  localparam int CW = (AW + 1 > BASE_W) ? AW + 1 : BASE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(MEM_DEPTH);
  localparam logic [SIZE_W-1:0] LIMIT_C = SIZE_W'(SIZE_LIMIT);

  logic [COUNT_W-1:0] stack_count;
  logic [SIZE_W-1:0]  size_q [SIZE_REGS];
  logic [FILL_W-1:0]  fill [USED_SLOTS];

  logic [SIZE_W-1:0] clamp [SIZE_REGS];
  logic [CW-1:0]     base;
  logic [CW-1:0]     room;
  logic [CW-1:0]     cap;
  logic [SIZE_W-1:0] size_sel;
  logic [FILL_W-1:0] fill_sel;
  logic [CW-1:0]     fill_ext;
  logic [CW-1:0]     addr_full;
  logic              in_use;

  // Clamp sizes, sum the regions below the addressed stack
  always_comb begin
    base     = '0;
    size_sel = '0;
    fill_sel = '0;
    for (int i = 0; i < SIZE_REGS; i++) begin
      clamp[i] = (size_q[i] > LIMIT_C) ? LIMIT_C : size_q[i];
      if (2'(i) < stack_number) begin
        base = base + CW'(clamp[i]);
      end
      if (2'(i) == stack_number) begin
        size_sel = clamp[i];
      end
    end
    for (int i = 0; i < USED_SLOTS; i++) begin
      if (2'(i) == stack_number) begin
        fill_sel = fill[i];
      end
    end
  end

  // Cut the region at the end of memory
  always_comb begin
    room = DEPTH_C - base;
    if (base >= DEPTH_C) begin
      cap = '0;
    end else if (CW'(size_sel) > room) begin
      cap = room;
    end else begin
      cap = CW'(size_sel);
    end
  end

  assign in_use   = ({1'b0, stack_number} < stack_count) &&
                    ({30'b0, stack_number} < 32'(USED_SLOTS));
  assign fill_ext = CW'(fill_sel);

  // Decide the outcome and the element address
  always_comb begin
    dec.status = ST_OK;
    dec.wr     = 1'b0;
    dec.rd     = 1'b0;
    addr_full  = base + fill_ext;
    if (!in_use) begin
      dec.status = ST_BAD_STACK;
    end else if (req_type == REQ_PUSH) begin
      if (fill_ext >= cap) begin
        dec.status = ST_OVERFLOW;
      end else begin
        dec.wr = 1'b1;
      end
    end else begin
      addr_full = base + fill_ext - CW'(1);
      if (fill_sel == '0) begin
        dec.status = ST_UNDERFLOW;
      end else begin
        dec.rd = 1'b1;
      end
    end
  end

  assign addr = addr_full[AW-1:0];

  // Hold configuration, advance fill counts, drop them on any register write
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= COUNT_RESET;
      for (int i = 0; i < SIZE_REGS; i++) begin
        size_q[i] <= SIZE_RESET;
      end
      for (int i = 0; i < USED_SLOTS; i++) begin
        fill[i] <= '0;
      end
    end else if (cfg_we && cfg_index <= REG_SIZE_THREE) begin
      case (cfg_index)
        REG_STACK_COUNT: stack_count <= cfg_data[COUNT_W-1:0];
        REG_SIZE_ZERO:   size_q[0]   <= cfg_data[SIZE_W-1:0];
        REG_SIZE_ONE:    size_q[1]   <= cfg_data[SIZE_W-1:0];
        REG_SIZE_TWO:    size_q[2]   <= cfg_data[SIZE_W-1:0];
        REG_SIZE_THREE:  size_q[3]   <= cfg_data[SIZE_W-1:0];
        default:         stack_count <= stack_count;
      endcase
      for (int i = 0; i < USED_SLOTS; i++) begin
        fill[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < USED_SLOTS; i++) begin
        if (2'(i) == stack_number) begin
          if (dec.wr) begin
            fill[i] <= fill_sel + FILL_W'(1);
          end else if (dec.rd) begin
            fill[i] <= fill_sel - FILL_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> dv/stack_result_checker.sv
module stack_result_checker import mss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [STK_W-1:0]     stack_number,
  input  logic [DATA_W-1:0]    push_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DATA_W-1:0]    pop_value,
  input  logic [STATUS_W-1:0]  status,
  output int                   mismatch_count,
  output int                   outcomes_owed
);

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    status_t           status;
  } outcome_t;

  // Shadow copy of the stacks and their configuration
  logic [DATA_W-1:0]  element_copy [DEF_MEM_DEPTH];
  logic [FILL_W-1:0]  fill_copy    [DEF_STACK_SLOTS];
  logic [COUNT_W-1:0] count_copy;
  logic [SIZE_W-1:0]  size_copy    [SIZE_REGS];
  outcome_t           owed_outcomes [$];
  int                 errors_seen = 0;

  // Capacity of one stack after the size limit is applied
  function automatic int clamped_cap(input int idx);
    int s;
    s = size_copy[idx];
    return (s > SIZE_LIMIT) ? SIZE_LIMIT : s;
  endfunction

  // Apply one request to the shadow stacks and return what the block must answer
  function automatic outcome_t serve_request(input logic [REQ_W-1:0]  kind,
                                             input logic [STK_W-1:0]  stk,
                                             input logic [DATA_W-1:0] word);
    outcome_t res;
    int       base;
    int       cap;
    int       fill;
    int       i;
    res.pop_value = '0;
    res.status    = ST_OK;
    base          = 0;
    if (stk >= count_copy || stk >= DEF_STACK_SLOTS || stk >= SIZE_REGS) begin
      res.status = ST_BAD_STACK;
    end else begin
      for (i = 0; i < stk; i++) base += clamped_cap(i);
      cap = clamped_cap(stk);
      // Cut the region at the end of memory
      if (base >= DEF_MEM_DEPTH) cap = 0;
      else if (cap > DEF_MEM_DEPTH - base) cap = DEF_MEM_DEPTH - base;
      fill = fill_copy[stk];
      if (kind == REQ_PUSH) begin
        if (fill >= cap) begin
          res.status = ST_OVERFLOW;
        end else begin
          element_copy[base + fill] = word;
          fill_copy[stk] = FILL_W'(fill + 1);
        end
      end else begin
        if (fill == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.pop_value  = element_copy[base + fill - 1];
          fill_copy[stk] = FILL_W'(fill - 1);
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t head;
    int       i;
    if (rst) begin
      count_copy = COUNT_RESET;
      for (i = 0; i < SIZE_REGS; i++) size_copy[i] = SIZE_RESET;
      for (i = 0; i < DEF_STACK_SLOTS; i++) fill_copy[i] = '0;
      owed_outcomes.delete();
    end else begin
      // Track register writes; any write in range empties every stack
      if (cfg_we && cfg_index <= REG_SIZE_THREE) begin
        if (cfg_index == REG_STACK_COUNT) count_copy = cfg_data[COUNT_W-1:0];
        else size_copy[2'(cfg_index - REG_SIZE_ZERO)] = cfg_data[SIZE_W-1:0];
        for (i = 0; i < DEF_STACK_SLOTS; i++) fill_copy[i] = '0;
      end
      // Compare the result word with the oldest owed outcome
      if (out_valid && out_ready) begin
        if (owed_outcomes.size() == 0) begin
          $display("%0t: result word with nothing owed: pop_value %h status %0d",
                   $time, pop_value, status);
          errors_seen++;
        end else begin
          head = owed_outcomes.pop_front();
          if (pop_value !== head.pop_value) begin
            $display("%0t: pop_value mismatch: expected %h actual %h",
                     $time, head.pop_value, pop_value);
            errors_seen++;
          end
          if (status !== head.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, head.status, status);
            errors_seen++;
          end
        end
      end
      // Predict the outcome of each accepted request word
      if (in_valid && in_ready)
        owed_outcomes.push_back(serve_request(req_type, stack_number, push_value));
    end
    outcomes_owed  <= owed_outcomes.size();
    mismatch_count <= errors_seen;
  end

endmodule

>>> dv/multi_stack_shared_memory_tb.sv
module multi_stack_shared_memory_tb;
  import mss_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int CYCLE_LIMIT = 400000;
  // Index past the last register; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 3'd7;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     req_type     = REQ_PUSH;
  logic [STK_W-1:0]     stack_number = '0;
  logic [DATA_W-1:0]    push_value   = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [DATA_W-1:0]    pop_value;
  logic [STATUS_W-1:0]  status;

  int                   mismatch_count;
  int                   outcomes_owed;
  int                   cycle_count    = 0;
  int                   stall_left     = 0;
  bit                   sender_burst   = 1'b0;
  bit                   receiver_burst = 1'b0;
  logic [COUNT_W-1:0]   live_count     = COUNT_RESET;

  multi_stack_shared_memory DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .stack_number (stack_number),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pop_value    (pop_value),
    .status       (status)
  );

  stack_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .stack_number   (stack_number),
    .push_value     (push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pop_value      (pop_value),
    .status         (status),
    .mismatch_count (mismatch_count),
    .outcomes_owed  (outcomes_owed)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_stack_shared_memory_tb: done, errors");
      $finish;
    end
  end

  // Stall the result side for a random number of cycles after each word
  always @(posedge clk) begin : result_sink
    int hold;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (out_valid && out_ready) begin
      hold = receiver_burst ? 0 : $urandom_range(0, 7);
      stall_left <= hold;
      out_ready  <= (hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one request word after a random gap and hold it until taken
  task automatic send_word(input logic [REQ_W-1:0]  kind,
                           input logic [STK_W-1:0]  stk,
                           input logic [DATA_W-1:0] word);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    stack_number <= stk;
    push_value   <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drive one register write; the caller lowers cfg_we after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_STACK_COUNT) live_count = data[COUNT_W-1:0];
    @(posedge clk);
  endtask

  // Stop offering words and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcomes_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int                 items_left;
    int                 phase;
    int                 n_items;
    int                 push_pct;
    int                 favorite;
    int                 pick;
    int                 in_use;
    int                 r;
    logic [COUNT_W-1:0] cnt;
    logic [CFG_W-1:0]   sz;
    logic [STK_W-1:0]   stk;
    logic [REQ_W-1:0]   kind;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: value extremes, LIFO order, underflow on both ends
    send_word(REQ_PUSH, 2'd0, 32'h7FFF_FFFF);
    send_word(REQ_PUSH, 2'd0, 32'h8000_0000);
    send_word(REQ_PUSH, 2'd3, 32'h0000_0000);
    send_word(REQ_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_word(REQ_POP,  2'd0, 32'h1234_5678);
    send_word(REQ_POP,  2'd0, 32'h0);
    send_word(REQ_POP,  2'd0, 32'h0);
    send_word(REQ_POP,  2'd3, 32'h0);
    send_word(REQ_POP,  2'd3, 32'hFFFF_FFFF);
    send_word(REQ_POP,  2'd3, 32'h0);
    drain_results();

    // Two stacks, a one-entry stack, an empty stack, an oversized size
    write_reg(REG_STACK_COUNT, 7'd2);
    write_reg(REG_SIZE_ZERO, 7'd1);
    write_reg(REG_SIZE_ONE, 7'd0);
    write_reg(REG_SIZE_TWO, 7'd127);
    write_reg(REG_SIZE_THREE, 7'd64);
    write_reg(REG_UNUSED_TOP, 7'h7F);
    cfg_we <= 1'b0;
    send_word(REQ_PUSH, 2'd0, 32'hA5A5_5A5A);
    send_word(REQ_PUSH, 2'd0, 32'h0F0F_F0F0);
    send_word(REQ_PUSH, 2'd1, 32'h1111_1111);
    send_word(REQ_POP,  2'd1, 32'h0);
    send_word(REQ_PUSH, 2'd2, 32'h2222_2222);
    send_word(REQ_POP,  2'd3, 32'h0);
    send_word(REQ_POP,  2'd0, 32'h0);
    drain_results();

    // No stacks in use, then a count above four with its upper bits set
    write_reg(REG_STACK_COUNT, 7'd0);
    cfg_we <= 1'b0;
    send_word(REQ_PUSH, 2'd0, 32'h3333_3333);
    send_word(REQ_POP,  2'd2, 32'h0);
    drain_results();
    write_reg(REG_STACK_COUNT, 7'h7F);
    cfg_we <= 1'b0;
    send_word(REQ_PUSH, 2'd3, 32'hDEAD_BEEF);
    send_word(REQ_POP,  2'd3, 32'h0);
    drain_results();

    // Random phases, each with its own configuration and traffic mix
    items_left = ITEM_TARGET;
    phase      = 0;
    while (items_left > 0) begin
      sender_burst   = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      favorite       = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0:       push_pct = 30;
        1:       push_pct = 50;
        2:       push_pct = 70;
        default: push_pct = 85;
      endcase
      if (phase == 0) begin
        // Largest layout, push-heavy to fill stacks up to the top of memory
        write_reg(REG_STACK_COUNT, 7'd4);
        for (r = 0; r < SIZE_REGS; r++) write_reg(CFG_IDX_W'(REG_SIZE_ZERO + r), 7'd64);
        n_items  = 320;
        push_pct = 85;
      end else if (phase == 1) begin
        // Smallest layout: one stack with no room
        write_reg(REG_STACK_COUNT, 7'd1);
        for (r = 0; r < SIZE_REGS; r++) write_reg(CFG_IDX_W'(REG_SIZE_ZERO + r), 7'd0);
        n_items = 30;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, 15);
          if (pick < 10)      cnt = 3'd4;
          else if (pick < 13) cnt = COUNT_W'($urandom_range(1, 3));
          else if (pick == 13) cnt = 3'd0;
          else                cnt = COUNT_W'($urandom_range(5, 7));
          write_reg(REG_STACK_COUNT, {4'($urandom_range(0, 15)), cnt});
        end
        for (r = 0; r < SIZE_REGS; r++) begin
          if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)      sz = 7'd0;
            else if (pick == 1) sz = 7'd1;
            else if (pick < 8)  sz = CFG_W'($urandom_range(2, 8));
            else if (pick < 11) sz = CFG_W'($urandom_range(9, 32));
            else if (pick < 13) sz = 7'd64;
            else if (pick == 13) sz = CFG_W'($urandom_range(65, 127));
            else                sz = CFG_W'($urandom_range(2, 16));
            write_reg(CFG_IDX_W'(REG_SIZE_ZERO + r), sz);
          end
        end
        if ($urandom_range(0, 7) == 0)
          write_reg(CFG_IDX_W'(REG_SIZE_THREE + $urandom_range(1, 3)), 7'($urandom));
        n_items = $urandom_range(30, 90);
      end
      cfg_we <= 1'b0;
      if (n_items > items_left) n_items = items_left;

      // Mostly stacks in use, biased to one favorite so it fills and empties
      in_use = (live_count > 4) ? 4 : live_count;
      repeat (n_items) begin
        pick = $urandom_range(0, 9);
        if (in_use == 0 || pick == 0) stk = STK_W'($urandom_range(0, 3));
        else if (pick < 5 && favorite < in_use) stk = STK_W'(favorite);
        else stk = STK_W'($urandom_range(0, in_use - 1));
        kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        send_word(kind, stk, $urandom);
      end
      items_left -= n_items;
      phase++;
      drain_results();
    end

    // Let the pipeline settle, then give the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outcomes_owed == 0)
      $display("multi_stack_shared_memory_tb: done, clean");
    else
      $display("multi_stack_shared_memory_tb: done, errors");
    $finish;
  end

endmodule
